// ===== rtl/hets_pkg.sv =====
package hets_pkg;

  // character codes
  localparam logic [7:0] ChrAmp  = 8'h26;
  localparam logic [7:0] ChrLt   = 8'h3C;
  localparam logic [7:0] ChrGt   = 8'h3E;
  localparam logic [7:0] ChrNl   = 8'h0A;
  localparam logic [7:0] ChrApos = 8'h27;
  localparam logic [7:0] ChrB    = 8'h62;
  localparam logic [7:0] ChrR    = 8'h72;
  localparam logic [7:0] ChrG    = 8'h67;
  localparam logic [7:0] ChrT    = 8'h74;
  localparam logic [7:0] ChrHash = 8'h23;
  localparam logic [7:0] ChrZero = 8'h30;
  localparam logic [7:0] ChrThree = 8'h33;
  localparam logic [7:0] ChrNine = 8'h39;
  localparam logic [7:0] ChrSemi = 8'h3B;

  // entity kinds and their lengths
  localparam logic KindGt   = 1'b0;
  localparam logic KindApos = 1'b1;
  localparam logic [2:0] GtLen   = 3'd4;
  localparam logic [2:0] AposLen = 3'd6;

  // scanner state
  typedef struct packed {
    logic       in_tag;
    logic [1:0] tag_offset;
    logic       tag_b_seen;
    logic       entity_kind;
    logic [2:0] entity_matched;
  } hets_state_t;

  // result list of one request: held prefix bytes, then an optional extra byte
  typedef struct packed {
    logic [2:0] pre_cnt;
    logic       pre_kind;
    logic       ext_vld;
    logic [7:0] ext_chr;
    logic       last;
    logic [2:0] total;
  } hets_list_t;

  // byte at a position of the entity being matched, clamped to its end
  function automatic logic [7:0] held_byte(input logic kind, input logic [2:0] idx);
    logic [7:0] b;
    b = ChrSemi;
    if (kind == KindApos) begin
      case (idx)
        3'd0: b = ChrAmp;
        3'd1: b = ChrHash;
        3'd2: b = ChrZero;
        3'd3: b = ChrThree;
        3'd4: b = ChrNine;
        default: b = ChrSemi;
      endcase
    end else begin
      case (idx)
        3'd0: b = ChrAmp;
        3'd1: b = ChrG;
        3'd2: b = ChrT;
        default: b = ChrSemi;
      endcase
    end
    return b;
  endfunction

endpackage

// ===== rtl/hets_if.sv =====
interface hets_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_in;

  modport source (output valid, output char_in, output last_in, input ready);
  modport sink (input valid, input char_in, input last_in, output ready);
endinterface

interface hets_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       has_char;
  logic       end_out;

  modport source (output valid, output char_out, output has_char, output end_out,
                  input ready);
  modport sink (input valid, input char_out, input has_char, input end_out,
                output ready);
endinterface

// ===== rtl/html_entity_tag_stripper_top.sv =====
// Cleans post text one byte per request: "&gt;" becomes '>', "&#039;" becomes a single
// quote, a '<' ... '>' span is dropped (a newline is sent for one starting "<br"), and
// a partly matched entity that fails goes out literally. A byte is taken every cycle
// while it yields at most one output byte and out_o is ready; a request yielding several
// (a flushed entity prefix, up to six bytes in all) holds the input until all are sent,
// one byte a cycle while out_o is ready. The last request always ends with one result
// marked end_out, a bare marker with has_char low if it had nothing else to send.
module html_entity_tag_stripper_top import hets_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  hets_in_if.sink  in_i,
  hets_out_if.source out_o
);

  hets_list_t list;
  logic       free;
  logic       acc;

  assign in_i.ready = free;
  assign acc        = in_i.valid && free;

  // byte scanner and its state
  hets_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .char_i (in_i.char_in),
    .last_i (in_i.last_in),
    .list_o (list)
  );

  // result register and serializer
  hets_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (acc),
    .list_i (list),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

// ===== rtl/hets_ctrl.sv =====
module hets_ctrl import hets_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output hets_list_t list_o
);

  hets_state_t state_q, state_d;
  hets_list_t  list;
  logic        do_fresh;
  logic [2:0]  ent_len;
  logic [2:0]  m_next;

  // scan one byte: tag filter, entity matcher, literal pass
  always_comb begin
    state_d       = state_q;
    list.pre_cnt  = 3'd0;
    list.pre_kind = state_q.entity_kind;
    list.ext_vld  = 1'b0;
    list.ext_chr  = char_i;
    list.last     = last_i;
    list.total    = 3'd0;
    do_fresh      = 1'b0;
    ent_len       = (state_q.entity_kind == KindApos) ? AposLen : GtLen;
    m_next        = state_q.entity_matched + 3'd1;

    if (state_q.in_tag) begin
      if (char_i == ChrGt) begin
        state_d.in_tag     = 1'b0;
        state_d.tag_offset = 2'd0;
        state_d.tag_b_seen = 1'b0;
      end else if (state_q.tag_offset == 2'd0) begin
        state_d.tag_b_seen = (char_i == ChrB);
        state_d.tag_offset = 2'd1;
      end else if (state_q.tag_offset == 2'd1) begin
        if (state_q.tag_b_seen && char_i == ChrR) begin
          list.ext_vld = 1'b1;
          list.ext_chr = ChrNl;
        end
        state_d.tag_offset = 2'd2;
      end
    end else if (state_q.entity_matched == 3'd0) begin
      do_fresh = 1'b1;
    end else if (state_q.entity_matched == 3'd1) begin
      if (char_i == ChrG) begin
        state_d.entity_kind    = KindGt;
        state_d.entity_matched = 3'd2;
      end else if (char_i == ChrHash) begin
        state_d.entity_kind    = KindApos;
        state_d.entity_matched = 3'd2;
      end else begin
        list.pre_cnt           = 3'd1;
        state_d.entity_matched = 3'd0;
        do_fresh               = 1'b1;
      end
    end else begin
      if (state_q.entity_matched < ent_len &&
          char_i == held_byte(state_q.entity_kind, state_q.entity_matched)) begin
        if (m_next == ent_len) begin
          state_d.entity_matched = 3'd0;
          list.ext_vld = 1'b1;
          list.ext_chr = (state_q.entity_kind == KindApos) ? ChrApos : ChrGt;
        end else begin
          state_d.entity_matched = m_next;
        end
      end else begin
        list.pre_cnt           = state_q.entity_matched;
        state_d.entity_matched = 3'd0;
        do_fresh               = 1'b1;
      end
    end

    // byte handled afresh outside any entity
    if (do_fresh) begin
      if (char_i == ChrAmp) begin
        state_d.entity_matched = 3'd1;
        state_d.entity_kind    = KindGt;
      end else if (char_i == ChrLt) begin
        state_d.in_tag     = 1'b1;
        state_d.tag_offset = 2'd0;
        state_d.tag_b_seen = 1'b0;
      end else begin
        list.ext_vld = 1'b1;
      end
    end

    // end of text: flush what is still held, then back to reset state
    if (last_i) begin
      if (list.pre_cnt == 3'd0) begin
        list.pre_cnt  = state_d.entity_matched;
        list.pre_kind = state_d.entity_kind;
      end else if (state_d.entity_matched != 3'd0) begin
        list.ext_vld = 1'b1;
        list.ext_chr = ChrAmp;
      end
      state_d = '0;
    end

    list.total = list.pre_cnt + {2'b00, list.ext_vld};
    if (list.total == 3'd0 && last_i) begin
      list.total = 3'd1;
    end
  end

  assign list_o = list;

  // scanner state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (acc_i) begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/hets_outbuf.sv =====
module hets_outbuf import hets_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  hets_list_t list_i,
  output logic       free_o,
  hets_out_if.source out_o
);

  hets_list_t list_q;
  logic       busy_q, busy_d;
  logic [2:0] idx_q, idx_d;
  logic       in_pre;
  logic       at_end;
  logic       take;

  assign in_pre = (idx_q < list_q.pre_cnt);
  assign at_end = (idx_q == list_q.total - 3'd1);
  assign take   = busy_q && out_o.ready;
  assign free_o = !busy_q || (take && at_end);

  // current result of the held list
  assign out_o.valid    = busy_q;
  assign out_o.char_out = in_pre ? held_byte(list_q.pre_kind, idx_q)
                        : (list_q.ext_vld ? list_q.ext_chr : 8'h00);
  assign out_o.has_char = in_pre || list_q.ext_vld;
  assign out_o.end_out  = list_q.last && at_end;

  // walk the list, reload once its last result is taken
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (take) begin
      if (at_end) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
    if (load_i) begin
      busy_d = (list_i.total != 3'd0);
      idx_d  = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  // result list payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      list_q <= list_i;
    end
  end

endmodule
